@@ rtl/thumbstick_radial_deadzone_top_macros.svh @@
// Assertion macros shared by the deadzone normalizer RTL
`ifndef THUMBSTICK_RADIAL_DEADZONE_TOP_MACROS_SVH
`define THUMBSTICK_RADIAL_DEADZONE_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset
`define TDZ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdz check failed");

// Next-cycle implication, also checked during reset
`define TDZ_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tdz check failed");

`endif

@@ rtl/tdz_pkg.sv @@
// Types, constants and the divider step shared by the deadzone normalizer
package tdz_pkg;

   localparam logic [14:0] DeadzoneReset = 15'd4000;
   localparam logic [14:0] MagClamp      = 15'd32767;
   localparam int          SqrtCells     = 24;
   localparam int          DivCells      = 16;

   typedef struct packed {
      logic        sign_x;
      logic        sign_y;
      logic [16:0] abs_x;
      logic [16:0] abs_y;
   } side_type;

   typedef struct packed {
      logic [25:0] rem;
      logic [23:0] root;
      logic [47:0] rad;
      side_type    side;
   } sqrt_word_type;

   typedef struct packed {
      logic [23:0] rem;
      logic [15:0] lo;
   } lane_type;

   typedef struct packed {
      lane_type    lane_x;
      lane_type    lane_y;
      lane_type    lane_s;
      logic [23:0] mag;
      logic [23:0] den;
      logic        sign_x;
      logic        sign_y;
      logic        mag_zero;
      logic        active;
   } div_word_type;

   // One restoring division step: bring down a dividend bit, shift in a quotient bit
   function automatic lane_type div_step(input lane_type a, input logic [23:0] d);
      logic [24:0] t;
      logic [24:0] s;
      lane_type    r;
      t = {a.rem, a.lo[15]};
      s = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         r.rem = s[23:0];
         r.lo  = {a.lo[14:0], 1'b1};
      end else begin
         r.rem = t[23:0];
         r.lo  = {a.lo[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ rtl/tdz_if.sv @@
// Request and response channel interfaces of the deadzone normalizer
interface tdz_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   modport source(output valid, output stick_x, output stick_y, input ready);
   modport sink(input valid, input stick_x, input stick_y, output ready);
endinterface

interface tdz_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic        [15:0] strength;
   modport source(output valid, output dir_x, output dir_y, output strength, input ready);
   modport sink(input valid, input dir_x, input dir_y, input strength, output ready);
endinterface

@@ rtl/tdz_sqrt_cell.sv @@
// One digit cell of the square root chain: two radicand bits in, one root bit out
module tdz_sqrt_cell
   import tdz_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  sqrt_word_type in_word,
   output logic          out_valid,
   output sqrt_word_type out_word
);

   logic          valid_ff;
   logic          valid_in;
   sqrt_word_type word_ff;
   sqrt_word_type word_in;
   logic [27:0]   rem_ext;
   logic [27:0]   trial;
   logic [27:0]   diff;

   always_comb begin
      rem_ext      = {in_word.rem, in_word.rad[47:46]};
      trial        = {2'b00, in_word.root, 2'b01};
      diff         = rem_ext - trial;
      word_in      = in_word;
      word_in.rad  = {in_word.rad[45:0], 2'b00};
      if (rem_ext >= trial) begin
         word_in.rem  = diff[25:0];
         word_in.root = {in_word.root[22:0], 1'b1};
      end else begin
         word_in.rem  = rem_ext[25:0];
         word_in.root = {in_word.root[22:0], 1'b0};
      end
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ rtl/tdz_div_cell.sv @@
// One step cell of the divider chain: one quotient bit for each of three lanes
module tdz_div_cell
   import tdz_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  div_word_type in_word,
   output logic         out_valid,
   output div_word_type out_word
);

   logic         valid_ff;
   logic         valid_in;
   div_word_type word_ff;
   div_word_type word_in;

   always_comb begin
      word_in        = in_word;
      word_in.lane_x = div_step(in_word.lane_x, in_word.mag);
      word_in.lane_y = div_step(in_word.lane_y, in_word.mag);
      word_in.lane_s = div_step(in_word.lane_s, in_word.den);
      valid_in       = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ rtl/thumbstick_radial_deadzone_top.sv @@
// Squares, 24 root cells and 16 divider cells run in one pipe.
// Throughput: one word per cycle while the pipe is not held.
// The whole pipe holds only while the output register is full and not taken.
// Reset clears every valid bit and loads the deadzone register with 4000.
// No clearing pass: the block takes words in the first cycle after reset.
module thumbstick_radial_deadzone_top
   import tdz_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tdz_req_if.sink       req_bus,
   tdz_rsp_if.source     rsp_bus,
   input  logic          csr_wr_en,
   input  logic [14:0]   csr_wr_data
);

`include "thumbstick_radial_deadzone_top_macros.svh"

   logic          advance;
   logic [14:0]   deadzone_ff;
   logic [14:0]   deadzone_in;

   // square stage
   logic          sq_valid_ff;
   logic [31:0]   sqx_ff;
   logic [31:0]   sqy_ff;
   side_type      sq_side_ff;
   side_type      side_in;
   logic [16:0]   ext_x;
   logic [16:0]   ext_y;
   logic [33:0]   sqx_full;
   logic [33:0]   sqy_full;

   // sum stage
   logic          sum_valid_ff;
   logic [31:0]   sum_ff;
   side_type      sum_side_ff;

   logic          sqrt_valid [0:SqrtCells];
   sqrt_word_type sqrt_word  [0:SqrtCells];

   // divider setup stage
   logic          prep_valid_ff;
   div_word_type  prep_ff;
   div_word_type  prep_in;
   logic [23:0]   mag;
   logic [23:0]   clamp8;
   logic [23:0]   mag_clamped;
   logic [23:0]   dz8;
   logic [23:0]   numer;
   logic [14:0]   span;

   logic          div_valid [0:DivCells];
   div_word_type  div_word  [0:DivCells];

   // output register
   logic          rsp_valid_ff;
   logic [15:0]   dir_x_ff;
   logic [15:0]   dir_y_ff;
   logic [15:0]   strength_ff;
   logic [15:0]   dir_x_in;
   logic [15:0]   dir_y_in;
   logic [15:0]   strength_in;
   div_word_type  fin;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign deadzone_in = csr_wr_en ? csr_wr_data : deadzone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= DeadzoneReset;
      end else begin
         deadzone_ff <= deadzone_in;
      end
   end

   always_comb begin
      ext_x          = {req_bus.stick_x[15], req_bus.stick_x};
      ext_y          = {req_bus.stick_y[15], req_bus.stick_y};
      side_in.sign_x = req_bus.stick_x[15];
      side_in.sign_y = req_bus.stick_y[15];
      side_in.abs_x  = ext_x[16] ? (17'd0 - ext_x) : ext_x;
      side_in.abs_y  = ext_y[16] ? (17'd0 - ext_y) : ext_y;
      sqx_full       = {17'd0, side_in.abs_x} * {17'd0, side_in.abs_x};
      sqy_full       = {17'd0, side_in.abs_y} * {17'd0, side_in.abs_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff  <= req_bus.valid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff      <= sqx_full[31:0];
         sqy_ff      <= sqy_full[31:0];
         sq_side_ff  <= side_in;
         sum_ff      <= sqx_ff + sqy_ff;
         sum_side_ff <= sq_side_ff;
      end
   end

   // root of sum << 16 gives the magnitude with 8 fraction bits
   always_comb begin
      sqrt_valid[0]     = sum_valid_ff;
      sqrt_word[0].rem  = 26'd0;
      sqrt_word[0].root = 24'd0;
      sqrt_word[0].rad  = {sum_ff, 16'd0};
      sqrt_word[0].side = sum_side_ff;
   end

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      tdz_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sqrt_valid[i]),
         .in_word   (sqrt_word[i]),
         .out_valid (sqrt_valid[i+1]),
         .out_word  (sqrt_word[i+1])
      );
   end

   always_comb begin
      mag         = sqrt_word[SqrtCells].root;
      clamp8      = {1'b0, MagClamp, 8'd0};
      mag_clamped = (mag > clamp8) ? clamp8 : mag;
      dz8         = {1'b0, deadzone_ff, 8'd0};
      span        = MagClamp - deadzone_ff;
      prep_in.active   = mag_clamped > dz8;
      numer            = prep_in.active ? (mag_clamped - dz8) : 24'd0;
      prep_in.mag      = mag;
      prep_in.den      = {1'b0, span, 8'd0};
      prep_in.sign_x   = sqrt_word[SqrtCells].side.sign_x;
      prep_in.sign_y   = sqrt_word[SqrtCells].side.sign_y;
      prep_in.mag_zero = (mag == 24'd0);
      // dividend |v| << 23 split as high part |v| << 7 and sixteen zero bits
      prep_in.lane_x.rem = {sqrt_word[SqrtCells].side.abs_x, 7'd0};
      prep_in.lane_x.lo  = 16'd0;
      prep_in.lane_y.rem = {sqrt_word[SqrtCells].side.abs_y, 7'd0};
      prep_in.lane_y.lo  = 16'd0;
      // dividend numer << 15 split as high part numer >> 1 and low part numer[0] then fifteen zero bits
      prep_in.lane_s.rem = {1'b0, numer[23:1]};
      prep_in.lane_s.lo  = {numer[0], 15'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= sqrt_valid[SqrtCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign div_valid[0] = prep_valid_ff;
   assign div_word[0]  = prep_ff;

   for (genvar j = 0; j < DivCells; j++) begin : g_div
      tdz_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid[j]),
         .in_word   (div_word[j]),
         .out_valid (div_valid[j+1]),
         .out_word  (div_word[j+1])
      );
   end

   // apply sign, saturate +1.0 to the largest positive code, zero the directions at the origin
   always_comb begin
      fin = div_word[DivCells];
      if (fin.mag_zero) begin
         dir_x_in = 16'd0;
         dir_y_in = 16'd0;
      end else begin
         if (fin.sign_x) begin
            dir_x_in = 16'd0 - fin.lane_x.lo;
         end else begin
            dir_x_in = fin.lane_x.lo[15] ? 16'h7FFF : fin.lane_x.lo;
         end
         if (fin.sign_y) begin
            dir_y_in = 16'd0 - fin.lane_y.lo;
         end else begin
            dir_y_in = fin.lane_y.lo[15] ? 16'h7FFF : fin.lane_y.lo;
         end
      end
      strength_in = fin.active ? fin.lane_s.lo : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[DivCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_x_ff    <= dir_x_in;
         dir_y_ff    <= dir_y_in;
         strength_ff <= strength_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.dir_x    = dir_x_ff;
   assign rsp_bus.dir_y    = dir_y_ff;
   assign rsp_bus.strength = strength_ff;

   `TDZ_ASSERT_IMP(a_idle_ready, clock, reset, !rsp_valid_ff, req_bus.ready)
   `TDZ_ASSERT_IMP(a_strength_max, clock, reset, rsp_valid_ff, strength_ff <= 16'h8000)
   `TDZ_ASSERT_IMP(a_origin_quiet, clock, reset, div_valid[DivCells] && fin.mag_zero, !fin.active)
   `TDZ_ASSERT_NXT(a_reset_empty, clock, reset, !rsp_valid_ff && !prep_valid_ff)

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the thumbstick radial deadzone normalizer
class tdz_scoreboard;
   typedef struct {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [15:0]        strength;
   } rsp_word_type;

   rsp_word_type pending_q[$];
   logic [14:0]  deadzone;
   int           errors;

   function new();
      deadzone = tdz_pkg::DeadzoneReset;
      errors = 0;
   endfunction

   // floor(sqrt(v)), bit by bit
   static function automatic logic [47:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 48;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[47:0];
   endfunction

   static function automatic logic [15:0] unit_component(input longint v, input longint mag);
      longint q;
      if (mag == 0) return 16'd0;
      q = (v * 64'sd8388608) / mag;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function void note_stick(input logic signed [15:0] sx, input logic signed [15:0] sy);
      longint       x;
      longint       y;
      longint       mag;
      longint       m;
      longint       dz8;
      longint       den;
      longint       st;
      rsp_word_type w;
      x = sx;
      y = sy;
      mag = int_sqrt((x * x + y * y) << 16);
      dz8 = longint'(deadzone) << 8;
      st = 0;
      if (mag > dz8) begin
         m = (mag > (64'd32767 << 8)) ? (64'd32767 << 8) : mag;
         den = (64'd32767 - deadzone) << 8;
         if (m > dz8 && den != 0) st = ((m - dz8) * 32768) / den;
      end
      w.dir_x = unit_component(x, mag);
      w.dir_y = unit_component(y, mag);
      w.strength = st[15:0];
      pending_q.push_back(w);
   endfunction

   function void check_result(input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic [15:0] st);
      rsp_word_type w;
      if (pending_q.size() == 0) begin
         $error("unexpected response word dir_x=%0d dir_y=%0d strength=%0d", dx, dy, st);
         errors++;
         return;
      end
      w = pending_q.pop_front();
      if (dx !== w.dir_x) begin
         $error("dir_x expected %0d actual %0d", w.dir_x, dx);
         errors++;
      end
      if (dy !== w.dir_y) begin
         $error("dir_y expected %0d actual %0d", w.dir_y, dy);
         errors++;
      end
      if (st !== w.strength) begin
         $error("strength expected %0d actual %0d", w.strength, st);
         errors++;
      end
   endfunction
endclass

module testbench;
   import tdz_pkg::*;

   localparam int PipeLatency = 44;
   localparam int CycleLimit  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycle_count = 0;

   tdz_req_if req_bus();
   tdz_rsp_if rsp_bus();
   tdz_scoreboard board = new();

   thumbstick_radial_deadzone_top dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // receiver: random stall, check every accepted word
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_result(rsp_bus.dir_x, rsp_bus.dir_y, rsp_bus.strength);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("** thumbstick_radial_deadzone_top: FAILED **");
         $finish;
      end
   end

   task automatic send_stick(input logic signed [15:0] sx, input logic signed [15:0] sy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.stick_x <= sx;
      req_bus.stick_y <= sy;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_stick(sx, sy);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
   endtask

   // write only with the pipe empty
   task automatic write_deadzone(input logic [14:0] dz);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= dz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.deadzone = dz;
   endtask

   task automatic send_random_stick();
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      int                 r;
      sx = 16'($urandom);
      sy = 16'($urandom);
      r = int'($urandom_range(9));
      if (r == 0) begin
         sx = 16'($urandom_range(200) - 100);
         sy = 16'($urandom_range(200) - 100);
      end else if (r == 1) begin
         sx = 16'sd0;
      end else if (r == 2) begin
         sy = 16'sd0;
      end else if (r == 3) begin
         sx = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
      end else if (r == 4) begin
         // hover near the deadzone edge
         sx = 16'(board.deadzone + $urandom_range(64) - 32);
         sy = 16'($urandom_range(40) - 20);
      end
      send_stick(sx, sy);
   endtask

   task automatic random_phase(input int count, input int sidle, input int ridle);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      repeat (count) send_random_stick();
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.stick_x <= '0;
      req_bus.stick_y <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: origin, extremes, axes, overshoot
      send_stick(16'sd0, 16'sd0);
      send_stick(16'sh7fff, 16'sh7fff);
      send_stick(16'sh8000, 16'sh8000);
      send_stick(16'sh8000, 16'sd0);
      send_stick(16'sd0, 16'sh8000);
      send_stick(16'sh7fff, 16'sd0);
      send_stick(16'sd0, 16'sh7fff);
      send_stick(16'sh8000, 16'sh7fff);
      send_stick(16'sd1, 16'sd0);
      send_stick(-16'sd1, -16'sd1);
      send_stick(16'sd4000, 16'sd0);
      send_stick(16'sd4001, 16'sd0);
      send_stick(16'sd3999, 16'sd1);
      send_stick(16'sh5555, 16'shaaaa);
      write_deadzone(15'd0);
      send_stick(16'sd1, 16'sd0);
      send_stick(16'sd0, 16'sd0);
      send_stick(16'sh8000, 16'sh8000);
      write_deadzone(15'd32766);
      send_stick(16'sh8000, 16'sd0);
      send_stick(16'sh7fff, 16'sh7fff);
      send_stick(16'sd32766, 16'sd0);
      send_stick(16'sd32767, 16'sd0);
      write_deadzone(15'h7fff);
      send_stick(16'sh8000, 16'sh8000);
      send_stick(16'sh7fff, 16'sd0);
      write_deadzone(15'd4000);
      random_phase(250, 25, 72);
      write_deadzone(15'd0);
      random_phase(100, 72, 25);
      // hold until the pipe is empty
      drain_results();
      write_deadzone(15'($urandom_range(32766)));
      random_phase(150, 72, 25);
      write_deadzone(15'($urandom));
      random_phase(125, 0, 0);
      write_deadzone(15'd32766);
      random_phase(100, 0, 0);
      drain_results();
      repeat (PipeLatency + 10) @(posedge clock);
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("** thumbstick_radial_deadzone_top: PASSED **");
      else
         $display("** thumbstick_radial_deadzone_top: FAILED **");
      $finish;
   end
endmodule
